@@ hw/rtl/spf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Shortest-period-first scheduler package
// Shared constants, types and the probability saturating helper.
// -----------------------------------------------------------------------------
package spf_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [16:0] PROB_ONE = 17'd65536;

  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_SCHEDULE = 2'd1,
    FUNC_SET_PROB = 2'd2,
    FUNC_UNUSED   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RX   = 2'd1,
    MODE_TX   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_POWER  = 2'd0,
    CFG_FREQ   = 2'd1,
    CFG_LISTEN = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  // Data one cell hands to its neighbour: the best candidate seen so far.
  typedef struct packed {
    logic              found;
    logic [19:0]       period;
    logic [SLOT_W-1:0] slot;
  } best_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic              ins;
    logic [SLOT_W-1:0] ins_slot;
    logic              upd;
    logic [SLOT_W-1:0] upd_slot;
    logic              upd_free;
    logic [16:0]       upd_acc;
  } cell_ctl_t;

  function automatic logic [16:0] sat_prob(input logic [16:0] v);
    return (v > PROB_ONE) ? PROB_ONE : v;
  endfunction

endpackage : spf_pkg
`default_nettype wire

@@ hw/rtl/spf_slot_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Slot cell
// Holds one packet slot and forwards the running best candidate each cycle.
// -----------------------------------------------------------------------------
module spf_slot_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [spf_pkg::SLOT_W-1:0] my_slot,
  input  wire spf_pkg::cell_ctl_t        ctl,
  input  wire logic [15:0]               in_ident,
  input  wire logic                      in_periodic,
  input  wire logic [19:0]               in_period,
  input  wire logic [16:0]               in_req,
  input  wire spf_pkg::best_t            best_in,
  output spf_pkg::best_t                 best_out,
  output logic                           valid,
  output logic                           sent_before,
  output logic [15:0]                    ident,
  output logic [16:0]                    req,
  output logic [16:0]                    acc
);
  import spf_pkg::*;

  logic        valid_r, sent_r, periodic_r;
  logic [15:0] ident_r;
  logic [19:0] period_r;
  logic [16:0] req_r, acc_r;
  logic        take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sent_r  <= 1'b0;
    end else if (ctl.ins && ctl.ins_slot == my_slot) begin
      valid_r <= 1'b1;
      sent_r  <= 1'b0;
    end else if (ctl.upd && ctl.upd_slot == my_slot) begin
      valid_r <= ~ctl.upd_free;
      sent_r  <= ~ctl.upd_free;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && ctl.ins_slot == my_slot) begin
      ident_r    <= in_ident;
      periodic_r <= in_periodic;
      period_r   <= in_period;
      req_r      <= in_req;
      acc_r      <= '0;
    end else if (ctl.upd && ctl.upd_slot == my_slot) begin
      acc_r <= ctl.upd_acc;
    end
  end

  // Strictly smaller wins, so the lower slot keeps a tie.
  assign take = valid_r && periodic_r &&
                (!best_in.found || period_r < best_in.period);

  always_comb begin
    best_out = best_in;
    if (take) begin
      best_out.found  = 1'b1;
      best_out.period = period_r;
      best_out.slot   = my_slot;
    end
  end

  assign valid       = valid_r;
  assign sent_before = sent_r;
  assign ident       = ident_r;
  assign req         = req_r;
  assign acc         = acc_r;

endmodule : spf_slot_cell
`default_nettype wire

@@ hw/rtl/shortest_period_first_tx_scheduler_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Shortest-period-first transmit scheduler
// Packet slot table with a serial tick modulo and a scan along a cell chain.
// -----------------------------------------------------------------------------
// Usage: raise start for one cycle with the request fields while busy is low.
// func selects insert, schedule or set probability. Each request gives exactly
// one result, shown for one cycle with out_valid high; the receiver cannot
// stall, so results are never held.
// Flow: insert, set probability and unused codes show their result in the
// cycle after the request is taken. A schedule request runs a bit-serial
// remainder of the 32-bit tick by the listen period in ST_MOD, and a receive
// window ends there. Otherwise a best-candidate token walks the chain of slot
// cells one cell per cycle in ST_SCAN; an idle frame then shows once ST_MUL
// is over, while a transmit passes through ST_MUL (multiply) and ST_UPD
// (update) and shows once ST_UPD is over. Every request keeps busy high until
// ST_DONE has passed, so the next request can only follow after that.
// Configuration may be written at any time the block is idle; a zero listen
// period behaves as one. Reset (synchronous, rst_n low) clears every slot, the
// sent flags, the current probability and the registers to their reset values.
// -----------------------------------------------------------------------------
module shortest_period_first_tx_scheduler_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_tick_now,
  input  wire logic [15:0] in_pkt_ident,
  input  wire logic        in_pkt_is_periodic,
  input  wire logic [19:0] in_pkt_period,
  input  wire logic [16:0] in_pkt_success_req,
  input  wire logic [16:0] in_predicted_prob,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  output logic             out_valid,
  output logic [1:0]       out_frame_mode,
  output logic [15:0]      out_out_power,
  output logic [31:0]      out_out_frequency,
  output logic [15:0]      out_sent_ident,
  output logic             out_remove_done,
  output logic             out_insert_refused
);
  import spf_pkg::*;

  logic [15:0] power_r;
  logic [31:0] freq_r;
  logic [15:0] listen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r  <= '0;
      freq_r   <= '0;
      listen_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POWER:  power_r  <= cfg_wdata[15:0];
        CFG_FREQ:   freq_r   <= cfg_wdata;
        CFG_LISTEN: listen_r <= cfg_wdata[15:0];
        default:    ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  logic [16:0] cur_prob_r;
  logic [31:0] tick_r;
  logic [16:0] rem_r;
  logic [5:0]  bit_cnt_r;
  logic [CNT_W-1:0] scan_cnt_r;
  best_t       tok_r;
  logic [33:0] prod_r;
  logic        sent_s_r;
  logic [15:0] ident_s_r;
  logic [16:0] req_s_r;
  logic [16:0] acc_new;
  logic [16:0] lp;

  logic        o_valid_r, o_rem_r, o_ref_r;
  logic [1:0]  o_mode_r;
  logic [15:0] o_pow_r, o_id_r;
  logic [31:0] o_freq_r;

  logic [SLOT_COUNT-1:0] v_vec, s_vec;
  logic [15:0] id_a  [SLOT_COUNT];
  logic [16:0] req_a [SLOT_COUNT];
  logic [16:0] acc_a [SLOT_COUNT];
  best_t       chain [SLOT_COUNT];
  cell_ctl_t   ctl;

  logic              accept;
  logic              has_free;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] scan_idx;
  logic [17:0]       rem_sh;
  logic [16:0]       rem_nxt;

  assign accept   = start && !busy;
  assign scan_idx = scan_cnt_r[SLOT_W-1:0];
  assign lp       = (listen_r == 16'd0) ? 17'd1 : {1'b0, listen_r};
  assign rem_sh   = {rem_r, tick_r[31]};
  assign rem_nxt  = (rem_sh >= {1'b0, lp}) ? 17'(rem_sh - {1'b0, lp}) : rem_sh[16:0];

  always_comb begin
    has_free  = 1'b0;
    free_slot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!v_vec[i]) begin
        has_free  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // Every cell compares against the token; the one under the scan index
  // hands its result back as the token for the next cell.
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    spf_slot_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .my_slot     (SLOT_W'(g)),
      .ctl         (ctl),
      .in_ident    (in_pkt_ident),
      .in_periodic (in_pkt_is_periodic),
      .in_period   (in_pkt_period),
      .in_req      (sat_prob(in_pkt_success_req)),
      .best_in     (tok_r),
      .best_out    (chain[g]),
      .valid       (v_vec[g]),
      .sent_before (s_vec[g]),
      .ident       (id_a[g]),
      .req         (req_a[g]),
      .acc         (acc_a[g])
    );
  end

  // Update value: first transmission takes p, later ones combine.
  always_comb begin
    logic [34:0] r;
    r = {1'b0, prod_r} + 35'd32768;
    if (!sent_s_r) acc_new = cur_prob_r;
    else if (r[34:16] > 19'(PROB_ONE)) acc_new = '0;
    else acc_new = PROB_ONE - r[32:16];
  end

  always_comb begin
    ctl          = '0;
    ctl.ins      = accept && in_func == FUNC_INSERT && has_free;
    ctl.ins_slot = free_slot;
    ctl.upd      = state_r == ST_UPD;
    ctl.upd_slot = tok_r.slot;
    ctl.upd_acc  = acc_new;
    ctl.upd_free = acc_new >= req_s_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = (in_func == FUNC_SCHEDULE) ? ST_MOD : ST_DONE;
      ST_MOD:  if (bit_cnt_r == 6'd31) state_nxt = (rem_nxt == '0) ? ST_DONE : ST_SCAN;
      ST_SCAN: if (scan_cnt_r == CNT_W'(SLOT_COUNT - 1)) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = tok_r.found ? ST_UPD : ST_DONE;
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = state_r != ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_prob_r <= '0;
      o_valid_r  <= 1'b0;
    end else begin
      o_valid_r <= 1'b0;
      if (accept && in_func == FUNC_SET_PROB) cur_prob_r <= sat_prob(in_predicted_prob);
      if (accept && in_func != FUNC_SCHEDULE) begin
        o_valid_r <= 1'b1;
        o_mode_r  <= MODE_IDLE;
        o_pow_r   <= '0;
        o_freq_r  <= '0;
        o_id_r    <= '0;
        o_rem_r   <= 1'b0;
        o_ref_r   <= (in_func == FUNC_INSERT) && !has_free;
      end
      if (state_r == ST_MOD && bit_cnt_r == 6'd31) begin
        // Final remainder bit decides a receive window.
        if (rem_nxt == '0) begin
          o_valid_r <= 1'b1;
          o_mode_r  <= MODE_RX;
          o_pow_r   <= power_r;
          o_freq_r  <= freq_r;
          o_id_r    <= '0;
          o_rem_r   <= 1'b0;
          o_ref_r   <= 1'b0;
        end
      end
      if (state_r == ST_MUL && !tok_r.found) begin
        o_valid_r <= 1'b1;
        o_mode_r  <= MODE_IDLE;
        o_pow_r   <= power_r;
        o_freq_r  <= freq_r;
        o_id_r    <= '0;
        o_rem_r   <= 1'b0;
        o_ref_r   <= 1'b0;
      end
      if (state_r == ST_UPD) begin
        o_valid_r <= 1'b1;
        o_mode_r  <= MODE_TX;
        o_pow_r   <= power_r;
        o_freq_r  <= freq_r;
        o_id_r    <= ident_s_r;
        o_rem_r   <= acc_new >= req_s_r;
        o_ref_r   <= 1'b0;
      end
    end
  end

  // Datapath: serial remainder, chain walk and product.
  always_ff @(posedge clk) begin
    if (accept) begin
      tick_r     <= in_tick_now;
      rem_r      <= '0;
      bit_cnt_r  <= '0;
      scan_cnt_r <= '0;
      tok_r      <= '0;
    end
    if (state_r == ST_MOD) begin
      rem_r     <= rem_nxt;
      tick_r    <= {tick_r[30:0], 1'b0};
      bit_cnt_r <= bit_cnt_r + 6'd1;
    end
    if (state_r == ST_SCAN) begin
      // The token steps through one cell per cycle.
      tok_r      <= chain[scan_idx];
      scan_cnt_r <= scan_cnt_r + CNT_W'(1);
    end
    if (state_r == ST_MUL) begin
      prod_r    <= (PROB_ONE - acc_a[tok_r.slot]) * (PROB_ONE - cur_prob_r);
      sent_s_r  <= s_vec[tok_r.slot];
      ident_s_r <= id_a[tok_r.slot];
      req_s_r   <= req_a[tok_r.slot];
    end
  end

  assign out_valid          = o_valid_r;
  assign out_frame_mode     = o_mode_r;
  assign out_out_power      = o_pow_r;
  assign out_out_frequency  = o_freq_r;
  assign out_sent_ident     = o_id_r;
  assign out_remove_done    = o_rem_r;
  assign out_insert_refused = o_ref_r;

  // The ST_DONE state after a receive window or idle frame shows nothing extra.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after request");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid)) else $error("two results back to back");
  a_remove_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_remove_done |-> out_frame_mode == MODE_TX)
    else $error("removal without transmit");

endmodule : shortest_period_first_tx_scheduler_unit
`default_nettype wire

@@ tb/sv/shortest_period_first_tx_scheduler_unit_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Shortest-period-first scheduler testbench
// Drives insert, schedule, set-probability and unused requests with random gaps,
// predicts every frame from a behavioural slot table and compares each
// result field by field as it appears on the output strobe.
// -----------------------------------------------------------------------------

// Holds a behavioural copy of the slot table and the queue of frames that the
// block still owes us.
class spf_frame_board;
  localparam int NSLOT = spf_pkg::SLOT_COUNT;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] power;
    logic [31:0] freq;
    logic [15:0] ident;
    logic        removed;
    logic        refused;
  } frame_t;

  bit          valid[NSLOT];
  logic [15:0] ident[NSLOT];
  bit          periodic[NSLOT];
  logic [19:0] period[NSLOT];
  logic [16:0] need[NSLOT];
  bit          sent[NSLOT];
  logic [16:0] accum[NSLOT];
  logic [16:0] cur_prob;
  logic [15:0] power_reg;
  logic [31:0] freq_reg;
  logic [15:0] listen_reg;
  frame_t      owed[$];
  int          errors;

  function new();
    foreach (valid[i]) begin
      valid[i] = 0;
      sent[i] = 0;
    end
    cur_prob = '0;
    power_reg = '0;
    freq_reg = '0;
    listen_reg = 16'd1;
    errors = 0;
  endfunction

  function void set_reg(spf_pkg::cfg_idx_t idx, logic [31:0] v);
    case (idx)
      spf_pkg::CFG_POWER:  power_reg = v[15:0];
      spf_pkg::CFG_FREQ:   freq_reg = v;
      spf_pkg::CFG_LISTEN: listen_reg = v[15:0];
      default: ;
    endcase
  endfunction

  function logic [16:0] clip(logic [16:0] v);
    return (v > 17'd65536) ? 17'd65536 : v;
  endfunction

  // Works out the frame for one accepted request and updates the table.
  function void note_request(spf_pkg::func_t f, logic [31:0] tick, logic [15:0] id,
                             bit per, logic [19:0] prd, logic [16:0] req,
                             logic [16:0] pred);
    frame_t      e;
    int          slot;
    logic [31:0] lp;
    logic [16:0] acc;
    logic [33:0] miss;
    logic [33:0] r;
    e = '0;
    slot = -1;
    case (f)
      spf_pkg::FUNC_INSERT: begin
        for (int i = 0; i < NSLOT; i++)
          if (!valid[i] && slot < 0) slot = i;
        if (slot < 0) e.refused = 1;
        else begin
          valid[slot] = 1;
          ident[slot] = id;
          periodic[slot] = per;
          period[slot] = prd;
          need[slot] = clip(req);
          sent[slot] = 0;
          accum[slot] = '0;
        end
      end
      spf_pkg::FUNC_SET_PROB: cur_prob = clip(pred);
      spf_pkg::FUNC_SCHEDULE: begin
        e.power = power_reg;
        e.freq = freq_reg;
        lp = (listen_reg == 0) ? 32'd1 : {16'd0, listen_reg};
        if (tick % lp == 0) e.mode = spf_pkg::MODE_RX;
        else begin
          for (int i = 0; i < NSLOT; i++)
            if (valid[i] && periodic[i] && (slot < 0 || period[i] < period[slot]))
              slot = i;
          if (slot >= 0) begin
            if (sent[slot]) begin
              miss = (34'd65536 - accum[slot]) * (34'd65536 - cur_prob);
              r = (miss + 34'd32768) >> 16;
              if (r > 34'd65536) r = 34'd65536;
              acc = 17'd65536 - r[16:0];
            end else acc = cur_prob;
            accum[slot] = acc;
            sent[slot] = 1;
            e.mode = spf_pkg::MODE_TX;
            e.ident = ident[slot];
            if (acc >= need[slot]) begin
              e.removed = 1;
              valid[slot] = 0;
              sent[slot] = 0;
            end
          end
        end
      end
      default: ;
    endcase
    owed.push_back(e);
  endfunction

  function void check_frame(frame_t got);
    frame_t e;
    if (owed.size() == 0) begin
      $display("%0t: unexpected frame, actual %h", $time, got);
      errors++;
      return;
    end
    e = owed.pop_front();
    if (got.mode !== e.mode) begin
      $display("%0t: frame_mode expected %0d actual %0d", $time, e.mode, got.mode);
      errors++;
    end
    if (got.power !== e.power) begin
      $display("%0t: power expected %h actual %h", $time, e.power, got.power);
      errors++;
    end
    if (got.freq !== e.freq) begin
      $display("%0t: frequency expected %h actual %h", $time, e.freq, got.freq);
      errors++;
    end
    if (got.ident !== e.ident) begin
      $display("%0t: sent_ident expected %h actual %h", $time, e.ident, got.ident);
      errors++;
    end
    if (got.removed !== e.removed) begin
      $display("%0t: remove_done expected %b actual %b", $time, e.removed, got.removed);
      errors++;
    end
    if (got.refused !== e.refused) begin
      $display("%0t: insert_refused expected %b actual %b", $time, e.refused,
               got.refused);
      errors++;
    end
  endfunction
endclass

module shortest_period_first_tx_scheduler_unit_tb;
  import spf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [31:0] in_tick_now;
  logic [15:0] in_pkt_ident;
  logic        in_pkt_is_periodic;
  logic [19:0] in_pkt_period;
  logic [16:0] in_pkt_success_req;
  logic [16:0] in_predicted_prob;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        out_valid;
  logic [1:0]  out_frame_mode;
  logic [15:0] out_out_power;
  logic [31:0] out_out_frequency;
  logic [15:0] out_sent_ident;
  logic        out_remove_done;
  logic        out_insert_refused;

  spf_frame_board board;
  int             gap_pct;
  int             quiet_cycles = 0;
  bit             finished;

  shortest_period_first_tx_scheduler_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Results cannot be held off, so every strobe is checked on the edge that
  // ends its cycle. The watchdog counts cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_frame({out_frame_mode, out_out_power, out_out_frequency,
                         out_sent_ident, out_remove_done, out_insert_refused});
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000 && !finished) begin
      $display("shortest_period_first_tx_scheduler_unit regression: fail");
      $finish;
    end
  end

  // Writes a register while the block is idle and mirrors it in the board.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  // Sends one request: optional random gap first, then holds start until the
  // block takes it. Prediction is made at the accepting edge. The block is
  // busy in the cycle after a request, so the extra edge costs nothing.
  task automatic send_request(func_t f, logic [31:0] tick, logic [15:0] id, bit per,
                              logic [19:0] prd, logic [16:0] req, logic [16:0] pred);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1;
    in_func <= f;
    in_tick_now <= tick;
    in_pkt_ident <= id;
    in_pkt_is_periodic <= per;
    in_pkt_period <= prd;
    in_pkt_success_req <= req;
    in_predicted_prob <= pred;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(f, tick, id, per, prd, req, pred);
    start <= 0;
    @(posedge clk);
  endtask

  // Waits until every owed frame has come, plus a short settle.
  task automatic drain();
    while (board.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic do_insert(bit per, logic [19:0] prd, logic [16:0] req);
    send_request(FUNC_INSERT, $urandom, 16'($urandom), per, prd, req, 17'($urandom));
  endtask

  task automatic do_schedule(logic [31:0] tick);
    send_request(FUNC_SCHEDULE, tick, 16'($urandom), 1'($urandom), 20'($urandom),
                 17'($urandom), 17'($urandom));
  endtask

  task automatic do_set_prob(logic [16:0] p);
    send_request(FUNC_SET_PROB, $urandom, 16'($urandom), 1'($urandom), 20'($urandom),
                 17'($urandom), p);
  endtask

  // One random request, biased towards well-formed insert and schedule flows.
  task automatic random_request();
    int          pick;
    logic [16:0] prob;
    logic [19:0] prd;
    pick = $urandom_range(99);
    prob = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    prd = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(8));
    if (pick < 30)
      do_insert($urandom_range(4) != 0, prd, prob);
    else if (pick < 80)
      do_schedule(($urandom_range(3) == 0) ? $urandom : $urandom_range(64));
    else if (pick < 95)
      do_set_prob(prob);
    else
      send_request(FUNC_UNUSED, $urandom, 16'($urandom), 1'($urandom), 20'($urandom),
                   17'($urandom), 17'($urandom));
  endtask

  initial begin
    logic [15:0] listen_set[5];
    board = new();
    finished = 0;
    gap_pct = 0;
    rst_n = 0;
    start = 0;
    in_func = FUNC_INSERT;
    in_tick_now = '0;
    in_pkt_ident = '0;
    in_pkt_is_periodic = 0;
    in_pkt_period = '0;
    in_pkt_success_req = '0;
    in_predicted_prob = '0;
    cfg_we = 0;
    cfg_index = CFG_POWER;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: schedule on an empty table with the reset listen period,
    // where every tick is a receive window.
    do_schedule(32'd7);
    drain();
    write_reg(CFG_POWER, 32'hFFFF);
    write_reg(CFG_FREQ, 32'hFFFF_FFFF);
    write_reg(CFG_LISTEN, 32'd0);
    do_schedule(32'hFFFF_FFFF);
    drain();
    write_reg(CFG_LISTEN, 32'hFFFF);
    do_schedule(32'd1);                        // idle: no packets
    do_schedule(32'd0);                        // receive window
    do_set_prob(17'h1FFFF);                    // saturates to one
    do_insert(1, 20'hFFFFF, 17'h1FFFF);
    do_insert(1, 20'd3, 17'd65536);
    do_insert(1, 20'd3, 17'd0);                // tie with the slot above
    do_insert(0, 20'd0, 17'd0);                // not periodic, never chosen
    do_set_prob(17'd0);
    do_schedule(32'd5);                        // first send, probability zero
    do_set_prob(17'd30000);
    do_schedule(32'd6);                        // combined update, no removal
    do_schedule(32'd6);                        // same packet again, still not removed
    send_request(FUNC_UNUSED, '1, '1, 1, '1, '1, '1);
    for (int i = 0; i < 14; i++) do_insert(1, 20'd9, 17'd65536);
    do_insert(1, 20'd1, 17'd5);                // refused: table full
    drain();

    // Random part in phases with differing gaps and settings. The listen
    // period cycles through its extremes and a few small values.
    listen_set = '{16'd1, 16'hFFFF, 16'd3, 16'd7, 16'd0};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_POWER, (ph == 4) ? 32'd0 : $urandom);
      write_reg(CFG_FREQ, (ph == 4) ? 32'd0 : $urandom);
      write_reg(CFG_LISTEN, listen_set[ph]);
      gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 53 : 35);
      for (int n = 0; n < 150; n++) begin
        random_request();
        if (n == 75) drain();                 // sender waits for all frames
      end
      drain();
    end

    repeat (60) @(posedge clk);
    finished = 1;
    if (board.errors == 0 && board.owed.size() == 0)
      $display("shortest_period_first_tx_scheduler_unit regression: pass");
    else
      $display("shortest_period_first_tx_scheduler_unit regression: fail");
    $finish;
  end
endmodule
